// File: hdl/cfmb_pkg.sv
// ----------------------------------------------------------------------------
// cfmb_pkg
// Shared widths, constants and register codes of the conductor mirror block.
// ----------------------------------------------------------------------------
package cfmb_pkg;

  localparam int DIR_W     = 16;
  localparam int CFG_W     = 48;
  localparam int LANE_W    = 16;
  localparam int NUM_LANES = 3;
  localparam int COS_W     = 20;
  localparam int OUT_W     = 32;
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 5;

  // fresnel term numerators and denominators at scale 2^48
  localparam int FR_W      = 59;
  localparam int DEN_W     = 31;
  localparam int NORM_ST   = 5;
  localparam int QUO_W     = 33;
  localparam int RATIO_LAT = NORM_ST + 1 + 32;

  // final quotient before saturation
  localparam int QX_W      = 38;
  localparam int LANE_LAT  = 4 + RATIO_LAT + 2 + QX_W + 1;

  localparam int MIRROR_TOL = 3;
  localparam logic [COS_W-1:0] COS_FLOOR = 20'd10;
  localparam logic [COS_W-1:0] DIV_FLOOR = 20'd105;

  localparam logic [CFG_W-1:0] ETA_RESET = 48'h1000_1000_1000;

  typedef enum logic [1:0] {
    REG_ETA  = 2'd0,
    REG_ABS  = 2'd1,
    REG_TINT = 2'd2
  } cfg_reg_t;

endpackage

// File: hdl/cfmb_ratio_div.sv
// ----------------------------------------------------------------------------
// cfmb_ratio_div
// Pipelined ratio unit: normalizes the denominator below 2^31, caps num at den,
// then forms floor(num * 2^32 / den) one quotient bit per stage; den 0 gives 0.
// ----------------------------------------------------------------------------
module cfmb_ratio_div (
  input  logic                       clk,
  input  logic [cfmb_pkg::FR_W-1:0]  num_i,
  input  logic [cfmb_pkg::FR_W-1:0]  den_i,
  output logic [cfmb_pkg::QUO_W-1:0] quo_o
);

  localparam int NW   = cfmb_pkg::FR_W;
  localparam int DW   = cfmb_pkg::DEN_W;
  localparam int NS   = cfmb_pkg::NORM_ST;
  localparam int QW   = cfmb_pkg::QUO_W;
  localparam int BITS = QW - 1;

  logic [NW-1:0] num_s [0:NS];
  logic [NW-1:0] den_s [0:NS];

  assign num_s[0] = num_i;
  assign den_s[0] = den_i;

  // greedy right shifts by 16, 8, 4, 2, 1 while the denominator stays >= 2^30
  for (genvar gi = 0; gi < NS; gi++) begin : g_norm
    localparam int SH = 1 << (NS - 1 - gi);
    always_ff @(posedge clk) begin
      if (|den_s[gi][NW-1:DW+SH-1]) begin
        num_s[gi+1] <= num_s[gi] >> SH;
        den_s[gi+1] <= den_s[gi] >> SH;
      end else begin
        num_s[gi+1] <= num_s[gi];
        den_s[gi+1] <= den_s[gi];
      end
    end
  end

  logic [DW-1:0] rem_s [0:BITS];
  logic [DW-1:0] dv_s  [0:BITS];
  logic [QW-1:0] q_s   [0:BITS];
  logic          dz_s  [0:BITS];

  logic [DW-1:0] den_n;
  logic [DW-1:0] num_c;
  logic          top_ge;

  always_comb begin
    den_n = den_s[NS][DW-1:0];
    if (num_s[NS] > NW'(den_n)) begin
      num_c = den_n;
    end else begin
      num_c = num_s[NS][DW-1:0];
    end
    top_ge = (num_c >= den_n);
  end

  always_ff @(posedge clk) begin
    rem_s[0] <= top_ge ? '0 : num_c;
    dv_s[0]  <= den_n;
    q_s[0]   <= QW'(top_ge);
    dz_s[0]  <= (den_n == '0);
  end

  for (genvar gj = 0; gj < BITS; gj++) begin : g_bit
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_s[gj], 1'b0};
      ge    = (trial >= {1'b0, dv_s[gj]});
    end
    always_ff @(posedge clk) begin
      rem_s[gj+1] <= ge ? DW'(trial - {1'b0, dv_s[gj]}) : trial[DW-1:0];
      dv_s[gj+1]  <= dv_s[gj];
      q_s[gj+1]   <= {q_s[gj][QW-2:0], ge};
      dz_s[gj+1]  <= dz_s[gj];
    end
  end

  assign quo_o = dz_s[BITS] ? '0 : q_s[BITS];

endmodule

// File: hdl/cfmb_lane.sv
// ----------------------------------------------------------------------------
// cfmb_lane
// One color channel: fresnel numerators and denominators, two ratio units,
// tint product and the pipelined divide by the floored cosine.
// ----------------------------------------------------------------------------
module cfmb_lane (
  input  logic                        clk,
  input  logic [cfmb_pkg::COS_W-1:0]  cos_i,
  input  logic [cfmb_pkg::LANE_W-1:0] eta_i,
  input  logic [cfmb_pkg::LANE_W-1:0] kabs_i,
  input  logic [cfmb_pkg::LANE_W-1:0] tint_i,
  output logic [cfmb_pkg::OUT_W-1:0]  res_o
);

  localparam int CW = cfmb_pkg::COS_W;
  localparam int FW = cfmb_pkg::FR_W;
  localparam int QW = cfmb_pkg::QUO_W;
  localparam int XW = cfmb_pkg::QX_W;
  localparam int RL = cfmb_pkg::RATIO_LAT;
  localparam int OW = cfmb_pkg::OUT_W;

  // stage 1: products
  logic [31:0]   ee_r, kk_r;
  logic [39:0]   c2_r;
  logic [35:0]   ecq_r;
  logic [CW-1:0] cq1_r;

  always_ff @(posedge clk) begin
    ee_r  <= 32'(eta_i) * 32'(eta_i);
    kk_r  <= 32'(kabs_i) * 32'(kabs_i);
    c2_r  <= 40'(cos_i) * 40'(cos_i);
    ecq_r <= 36'(eta_i) * 36'(cos_i);
    cq1_r <= cos_i;
  end

  // stage 2: eta^2 + k^2, 2 eta c at scale 2^48
  logic [32:0]   a_r;
  logic [39:0]   c2b_r;
  logic [52:0]   tec2_r;
  logic [CW-1:0] cq2_r;

  always_ff @(posedge clk) begin
    a_r    <= 33'(ee_r) + 33'(kk_r);
    c2b_r  <= c2_r;
    tec2_r <= {ecq_r, 17'b0};
    cq2_r  <= cq1_r;
  end

  // stage 3: a*c^2 and the second base term
  logic [56:0]   ac2_r;
  logic [57:0]   base2_r;
  logic [52:0]   tec3_r;
  logic [CW-1:0] cq3_r;

  always_ff @(posedge clk) begin
    ac2_r   <= 57'(a_r) * 57'(c2b_r[39:16]);
    base2_r <= 58'({a_r, 24'b0}) + 58'({c2b_r, 8'b0});
    tec3_r  <= tec2_r;
    cq3_r   <= cq2_r;
  end

  // stage 4: numerators clamp at zero
  logic [FW-1:0] p1, tec_w, base_w;
  logic [FW-1:0] n1_r, d1_r, n2_r, d2_r;
  logic [CW-1:0] cq4_r;

  always_comb begin
    p1     = FW'(ac2_r) + (FW'(1) << 48);
    tec_w  = FW'(tec3_r);
    base_w = FW'(base2_r);
  end

  always_ff @(posedge clk) begin
    n1_r  <= (p1 > tec_w) ? p1 - tec_w : '0;
    d1_r  <= p1 + tec_w;
    n2_r  <= (base_w > tec_w) ? base_w - tec_w : '0;
    d2_r  <= base_w + tec_w;
    cq4_r <= cq3_r;
  end

  logic [QW-1:0] q1, q2;

  cfmb_ratio_div u_r1 (.clk(clk), .num_i(n1_r), .den_i(d1_r), .quo_o(q1));
  cfmb_ratio_div u_r2 (.clk(clk), .num_i(n2_r), .den_i(d2_r), .quo_o(q2));

  logic [CW-1:0] cqd_r [0:RL-1];

  always_ff @(posedge clk) begin
    cqd_r[0] <= cq4_r;
    for (int i = 1; i < RL; i++) begin
      cqd_r[i] <= cqd_r[i-1];
    end
  end

  // stage 5: mean of the two ratios, divisor floor
  logic [QW:0]   fsum;
  logic [QW-1:0] fr_r;
  logic [CW-1:0] m5_r;

  assign fsum = {1'b0, q1} + {1'b0, q2};

  always_ff @(posedge clk) begin
    fr_r <= fsum[QW:1];
    m5_r <= (cqd_r[RL-1] > cfmb_pkg::DIV_FLOOR) ? cqd_r[RL-1] : cfmb_pkg::DIV_FLOOR;
  end

  // stage 6: tint product, the 2^11 of the divisor is taken off here
  logic [48:0] prod;

  assign prod = 49'(fr_r) * 49'(tint_i);

  logic [XW-1:0] x_s [0:XW];
  logic [CW-1:0] r_s [0:XW];
  logic [CW-1:0] m_s [0:XW];

  always_ff @(posedge clk) begin
    x_s[0] <= prod[48:11];
    r_s[0] <= '0;
    m_s[0] <= m5_r;
  end

  // restoring divide, quotient bits shift in where dividend bits leave
  for (genvar gk = 0; gk < XW; gk++) begin : g_div
    logic [CW:0] trial;
    logic        ge;
    always_comb begin
      trial = {r_s[gk], x_s[gk][XW-1]};
      ge    = (trial >= {1'b0, m_s[gk]});
    end
    always_ff @(posedge clk) begin
      r_s[gk+1] <= ge ? CW'(trial - {1'b0, m_s[gk]}) : trial[CW-1:0];
      x_s[gk+1] <= {x_s[gk][XW-2:0], ge};
      m_s[gk+1] <= m_s[gk];
    end
  end

  always_ff @(posedge clk) begin
    res_o <= (|x_s[XW][XW-1:OW]) ? '1 : x_s[XW][OW-1:0];
  end

endmodule

// File: hdl/conductor_fresnel_mirror_brdf.sv
// ----------------------------------------------------------------------------
// conductor_fresnel_mirror_brdf
// Specular term of a conductor mirror: mirror test, per-channel fresnel
// reflectance times tint over the cosine, unsigned Q16.16 saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the six Q1.15 direction components and pulse start. busy is
//   never raised, so a transfer is taken on every cycle start is high; one
//   direction pair per cycle can stream without gaps.
//   Output: out_valid is high for one cycle with red, green, blue and
//   is_mirror. A result shows up for each input transfer, in order; on its way
//   it passes three lanes of 38-stage ratio pipelines followed by
//   a 38-stage divide by the cosine, one quotient bit per stage.
//   Throughput: one item per cycle.
//   The receiver cannot stall; each result is offered exactly once.
//   Configuration: APB writes to eta (0x00), absorption (0x08) and tint
//   (0x10), 48-bit values in the low bits of pwdata; only while no items are
//   in flight. Reads return the stored value.
//   Reset (rst_n low, synchronous): empties the pipeline, eta returns to 1.0
//   per channel, absorption and tint to zero.
// ----------------------------------------------------------------------------
module conductor_fresnel_mirror_brdf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [cfmb_pkg::DIR_W-1:0]  in_out_x,
  input  logic [cfmb_pkg::DIR_W-1:0]  in_out_y,
  input  logic [cfmb_pkg::DIR_W-1:0]  in_out_z,
  input  logic [cfmb_pkg::DIR_W-1:0]  in_in_x,
  input  logic [cfmb_pkg::DIR_W-1:0]  in_in_y,
  input  logic [cfmb_pkg::DIR_W-1:0]  in_in_z,
  output logic                        out_valid,
  output logic [cfmb_pkg::OUT_W-1:0]  out_red,
  output logic [cfmb_pkg::OUT_W-1:0]  out_green,
  output logic [cfmb_pkg::OUT_W-1:0]  out_blue,
  output logic                        out_is_mirror,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cfmb_pkg::ADDR_W-1:0] paddr,
  input  logic [cfmb_pkg::DATA_W-1:0] pwdata,
  output logic [cfmb_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int DW = cfmb_pkg::DIR_W;
  localparam int CW = cfmb_pkg::COS_W;
  localparam int GW = cfmb_pkg::CFG_W;
  localparam int LW = cfmb_pkg::LANE_W;
  localparam int NL = cfmb_pkg::NUM_LANES;
  localparam int OW = cfmb_pkg::OUT_W;
  localparam int LL = cfmb_pkg::LANE_LAT;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // configuration registers
  logic [GW-1:0] eta_r, abs_r, tint_r;
  cfmb_pkg::cfg_reg_t reg_sel;
  logic cfg_wr;

  assign reg_sel = cfmb_pkg::cfg_reg_t'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_r  <= cfmb_pkg::ETA_RESET;
      abs_r  <= '0;
      tint_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        cfmb_pkg::REG_ETA:  eta_r  <= pwdata[GW-1:0];
        cfmb_pkg::REG_ABS:  abs_r  <= pwdata[GW-1:0];
        cfmb_pkg::REG_TINT: tint_r <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cfmb_pkg::REG_ETA:  prdata = cfmb_pkg::DATA_W'(eta_r);
      cfmb_pkg::REG_ABS:  prdata = cfmb_pkg::DATA_W'(abs_r);
      cfmb_pkg::REG_TINT: prdata = cfmb_pkg::DATA_W'(tint_r);
      default:            prdata = '0;
    endcase
  end

  // input stage: mirror test and floored cosine in Q.20
  logic signed [DW:0] sx, sy, sz;
  logic               mirror;
  logic [CW-1:0]      cq;

  always_comb begin
    sx = $signed({in_out_x[DW-1], in_out_x}) + $signed({in_in_x[DW-1], in_in_x});
    sy = $signed({in_out_y[DW-1], in_out_y}) + $signed({in_in_y[DW-1], in_in_y});
    sz = $signed({in_out_z[DW-1], in_out_z}) - $signed({in_in_z[DW-1], in_in_z});
    mirror = (sx >= -(DW+1)'(cfmb_pkg::MIRROR_TOL)) && (sx <= (DW+1)'(cfmb_pkg::MIRROR_TOL))
          && (sy >= -(DW+1)'(cfmb_pkg::MIRROR_TOL)) && (sy <= (DW+1)'(cfmb_pkg::MIRROR_TOL))
          && (sz >= -(DW+1)'(cfmb_pkg::MIRROR_TOL)) && (sz <= (DW+1)'(cfmb_pkg::MIRROR_TOL));
    if (!in_in_z[DW-1] && (|in_in_z[DW-2:0])) begin
      cq = {in_in_z[DW-2:0], 5'b0};
    end else begin
      cq = cfmb_pkg::COS_FLOOR;
    end
  end

  logic          v0_r, m0_r;
  logic [CW-1:0] cq0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    m0_r  <= mirror;
    cq0_r <= cq;
  end

  // lanes
  logic [OW-1:0] res [0:NL-1];

  for (genvar gl = 0; gl < NL; gl++) begin : g_lane
    cfmb_lane u_lane (
      .clk    (clk),
      .cos_i  (cq0_r),
      .eta_i  (eta_r[gl*LW +: LW]),
      .kabs_i (abs_r[gl*LW +: LW]),
      .tint_i (tint_r[gl*LW +: LW]),
      .res_o  (res[gl])
    );
  end

  logic [LL-1:0] vld_r, mir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LL-2:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    mir_r <= {mir_r[LL-2:0], m0_r};
  end

  // merge: gate the lanes with the mirror flag
  logic hit;
  assign hit = vld_r[LL-1] & mir_r[LL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    out_is_mirror <= hit;
    out_red       <= hit ? res[0] : '0;
    out_green     <= hit ? res[1] : '0;
    out_blue      <= hit ? res[2] : '0;
  end

endmodule

// File: hdl/cfmb_checker.sv
// ----------------------------------------------------------------------------
// cfmb_checker
// Port-level checks of the conductor mirror block, bound to the top level.
// ----------------------------------------------------------------------------
module cfmb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic [cfmb_pkg::DIR_W-1:0]  in_out_x,
  input logic [cfmb_pkg::DIR_W-1:0]  in_out_y,
  input logic [cfmb_pkg::DIR_W-1:0]  in_out_z,
  input logic [cfmb_pkg::DIR_W-1:0]  in_in_x,
  input logic [cfmb_pkg::DIR_W-1:0]  in_in_y,
  input logic [cfmb_pkg::DIR_W-1:0]  in_in_z,
  input logic                        out_valid,
  input logic [cfmb_pkg::OUT_W-1:0]  out_red,
  input logic [cfmb_pkg::OUT_W-1:0]  out_green,
  input logic [cfmb_pkg::OUT_W-1:0]  out_blue,
  input logic                        out_is_mirror,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [cfmb_pkg::ADDR_W-1:0] paddr,
  input logic [cfmb_pkg::DATA_W-1:0] pwdata,
  input logic [cfmb_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);

  // each transfer in is followed by its result
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##85 out_valid)
    else $error("result missing after input transfer");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 85))
    else $error("result without matching input transfer");

  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_mirror) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("non-mirror result carries color");

  a_flag_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_is_mirror |-> out_valid)
    else $error("mirror flag outside a result");

endmodule

bind conductor_fresnel_mirror_brdf cfmb_checker u_cfmb_checker (.*);
